>>> design/sha_pkg.sv
// SHA-256 package: shared types, initial hash values, round constants and
// the sigma functions. No dependencies.
`timescale 1ns / 1ps
package sha_pkg;

  typedef logic [7:0][31:0] word8_t;
  typedef logic [15:0][31:0] word16_t;

  // Requests from the message sequencer to the compression unit
  typedef struct packed {
    logic        start;
    logic        load_iv;
    logic        wr_en;
    logic [3:0]  wr_idx;
    logic [31:0] wr_word;
  } core_req_t;

  localparam word8_t IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    round_k = k;
  endfunction

endpackage

>>> design/sha_core.sv
// SHA-256 compression unit: one round per cycle over a shifting schedule
// window, chain value kept here. Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sha_pkg::core_req_t req_i,
  output logic               busy_o,
  output sha_pkg::word8_t    chain_o
);

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ROUND = 3'b010,
    C_FINAL = 3'b100
  } core_state_e;

  core_state_e      state_q, state_d;
  logic [5:0]       round_q, round_d;
  sha_pkg::word8_t  chain_q, chain_d;
  sha_pkg::word8_t  vars_q, vars_d;
  sha_pkg::word16_t win_q, win_d;

  logic [31:0] new_w, t1, t2;

  always_comb begin
    new_w = sha_pkg::ssig1(win_q[14]) + win_q[9] + sha_pkg::ssig0(win_q[1]) + win_q[0];
    t1 = vars_q[7] + sha_pkg::bsig1(vars_q[4])
         + ((vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]))
         + sha_pkg::round_k(round_q) + win_q[0];
    t2 = sha_pkg::bsig0(vars_q[0])
         + ((vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]));
  end

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    chain_d = chain_q;
    vars_d  = vars_q;
    win_d   = win_q;
    unique case (state_q)
      C_IDLE: begin
        if (req_i.load_iv) chain_d = sha_pkg::IV;
        if (req_i.wr_en) win_d[req_i.wr_idx] = req_i.wr_word;
        if (req_i.start) begin
          vars_d  = chain_q;
          round_d = '0;
          state_d = C_ROUND;
        end
      end
      C_ROUND: begin
        // advance the working variables and the schedule window together
        vars_d = {vars_q[6:4], vars_q[3] + t1, vars_q[2:0], t1 + t2};
        win_d  = {new_w, win_q[15:1]};
        round_d = round_q + 6'd1;
        if (round_q == sha_pkg::LAST_POS) state_d = C_FINAL;
      end
      C_FINAL: begin
        for (int i = 0; i < 8; i++) chain_d[i] = chain_q[i] + vars_q[i];
        state_d = C_IDLE;
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      round_q <= '0;
      chain_q <= sha_pkg::IV;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vars_q <= vars_d;
    win_q  <= win_d;
  end

  assign busy_o  = (state_q != C_IDLE);
  assign chain_o = chain_q;

endmodule

>>> design/sha256_message_hash_top.sv
// SHA-256 message hash top level: byte packing, padding sequencer and digest
// output. Depends on sha_pkg and sha_core.
`timescale 1ns / 1ps
// Usage:
//  Slave stream takes one message byte per transaction (tdata), tuser set
//  when the byte is present, tlast on the final transaction of a message.
//  A transaction with tuser low and tlast high ends the message with no
//  byte, so an empty message can be hashed.
//  Master stream returns eight transactions per message: digest word and
//  its index in tdata, tuser set when the padded message is longer than
//  MAX_MESSAGE_BYTES (the word is then zero), tlast on the eighth word.
//  A byte that does not close a 64-byte block leaves the slave side ready; one
//  that closes it waits for 64 rounds of the shared round unit plus start and
//  chain update. After the end transaction the padding bytes are pushed one a
//  cycle while no block is compressing, and each padded block goes through the
//  single round unit in the same way.
//  The slave side is not ready while compression, padding or output run.
//  A stalled master side holds the current word; nothing is dropped.
//  Reset restores the initial hash values and clears the length count.
module sha256_message_hash_top #(
  parameter int unsigned MAX_MESSAGE_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] has_byte
  input  logic        s_axis_tlast_i,   // end_of_message
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tuser_o,   // [0] too_long
  output logic        m_axis_tlast_o    // last_word
);

  localparam logic [10:0] MaxBlocks = 11'(MAX_MESSAGE_BYTES / 64);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WAIT = 4'b0010,
    ST_PAD  = 4'b0100,
    ST_OUT  = 4'b1000
  } top_state_e;

  top_state_e state_q, state_d;
  logic [23:0] asm_q, asm_d;
  logic [15:0] cnt_q, cnt_d;
  logic        ovf_q, ovf_d;
  logic        err_q, err_d;
  logic        pad_act_q, pad_act_d;
  logic        pad_first_q, pad_first_d;
  logic        len_ph_q, len_ph_d;
  logic        pad_done_q, pad_done_d;
  logic [5:0]  pad_pos_q, pad_pos_d;
  logic [2:0]  idx_q, idx_d;

  sha_pkg::core_req_t req;
  sha_pkg::word8_t    chain;
  logic               core_busy;

  logic        push;
  logic [5:0]  push_pos;
  logic [7:0]  push_byte;
  logic [7:0]  len_byte;
  logic [16:0] blk_sum;
  logic        s_acc, m_acc, err_now;
  logic [15:0] len_now;

  sha_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .busy_o (core_busy),
    .chain_o(chain)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_acc = m_axis_tvalid_o && m_axis_tready_i;

  // length field bytes: bit length is len * 8, only 19 bits wide
  always_comb begin
    unique case (pad_pos_q[2:0])
      3'd5:    len_byte = {5'd0, cnt_q[15:13]};
      3'd6:    len_byte = cnt_q[12:5];
      3'd7:    len_byte = {cnt_q[4:0], 3'd0};
      default: len_byte = 8'd0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    asm_d       = asm_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    err_d       = err_q;
    pad_act_d   = pad_act_q;
    pad_first_d = pad_first_q;
    len_ph_d    = len_ph_q;
    pad_done_d  = pad_done_q;
    pad_pos_d   = pad_pos_q;
    idx_d       = idx_q;
    push        = 1'b0;
    push_pos    = cnt_q[5:0];
    push_byte   = s_axis_tdata_i;
    len_now     = cnt_q;
    blk_sum     = '0;
    err_now     = 1'b0;
    req         = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          if (s_axis_tuser_i) begin
            if (&cnt_q) begin
              ovf_d = 1'b1;
            end else begin
              push    = 1'b1;
              len_now = cnt_q + 16'd1;
              cnt_d   = len_now;
            end
          end
          blk_sum = {1'b0, len_now} + 17'd72;
          err_now = ovf_d || ({5'd0, blk_sum[16:6]} > {5'd0, MaxBlocks});
          if (s_axis_tlast_i) begin
            err_d = err_now;
            if (err_now) begin
              // let a block closed by this byte finish before the output
              pad_act_d  = 1'b1;
              pad_done_d = 1'b1;
              state_d    = (push && push_pos == sha_pkg::LAST_POS) ? ST_WAIT : ST_OUT;
            end else begin
              pad_act_d   = 1'b1;
              pad_first_d = 1'b1;
              len_ph_d    = 1'b0;
              pad_done_d  = 1'b0;
              pad_pos_d   = len_now[5:0];
              state_d     = (push && push_pos == sha_pkg::LAST_POS) ? ST_WAIT : ST_PAD;
            end
          end else if (push && push_pos == sha_pkg::LAST_POS) begin
            state_d = ST_WAIT;
          end
        end
      end
      ST_PAD: begin
        push      = 1'b1;
        push_pos  = pad_pos_q;
        push_byte = pad_first_q ? sha_pkg::PAD_BYTE : (len_ph_q ? len_byte : 8'd0);
        pad_first_d = 1'b0;
        pad_pos_d   = pad_pos_q + 6'd1;
        if (!len_ph_q && pad_pos_d == sha_pkg::LEN_POS) len_ph_d = 1'b1;
        if (pad_pos_q == sha_pkg::LAST_POS) begin
          if (len_ph_q) pad_done_d = 1'b1;
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!core_busy) begin
          if (!pad_act_q)      state_d = ST_IDLE;
          else if (pad_done_q) state_d = ST_OUT;
          else                 state_d = ST_PAD;
        end
      end
      ST_OUT: begin
        if (m_acc) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            // drop the message state and restore the initial hash
            req.load_iv = 1'b1;
            cnt_d     = '0;
            ovf_d     = 1'b0;
            err_d     = 1'b0;
            asm_d     = '0;
            pad_act_d = 1'b0;
            state_d   = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (push) begin
      asm_d = {asm_q[15:0], push_byte};
      if (push_pos[1:0] == 2'd3) begin
        req.wr_en   = 1'b1;
        req.wr_idx  = push_pos[5:2];
        req.wr_word = {asm_q, push_byte};
      end
      req.start = (push_pos == sha_pkg::LAST_POS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      asm_q       <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      err_q       <= 1'b0;
      pad_act_q   <= 1'b0;
      pad_first_q <= 1'b0;
      len_ph_q    <= 1'b0;
      pad_done_q  <= 1'b0;
      pad_pos_q   <= '0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      asm_q       <= asm_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      err_q       <= err_d;
      pad_act_q   <= pad_act_d;
      pad_first_q <= pad_first_d;
      len_ph_q    <= len_ph_d;
      pad_done_q  <= pad_done_d;
      pad_pos_q   <= pad_pos_d;
      idx_q       <= idx_d;
    end
  end

  assign m_axis_tdata_o = {5'd0, idx_q, err_q ? 32'd0 : chain[idx_q]};
  assign m_axis_tuser_o = err_q;
  assign m_axis_tlast_o = (idx_q == 3'd7);

endmodule

>>> tb/tb_top.sv
// Self-checking bench for sha256_message_hash_top: random and directed messages
// are hashed by a behavioural SHA-256 predictor and compared word by word.
// Depends on sha_pkg (IV) and the DUT.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned MAX_BYTES = 256;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        too_long;
    logic        last;
  } digest_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = '0;
  logic        s_user = 1'b0;
  logic        s_last = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [39:0] m_data;
  logic        m_user;
  logic        m_last;

  sha256_message_hash_top #(.MAX_MESSAGE_BYTES(MAX_BYTES)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user), .m_axis_tlast_o(m_last)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Predictor state
  logic [7:0]  msg_bytes[$];
  logic [15:0] msg_len;
  logic        len_overflow;
  digest_beat_t digest_q[$];
  int unsigned mismatches = 0;
  bit          no_idle = 0;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic sha_compress(inout logic [31:0] h[8], input logic [7:0] blk[64]);
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    for (int i = 0; i < 8; i++) v[i] = h[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + w[r];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) h[i] += v[i];
  endtask

  // Work out the digest of the collected message and queue its eight words
  task automatic predict_digest();
    logic [31:0] h[8];
    logic [7:0]  blk[64];
    logic [7:0]  padded[$];
    logic [63:0] bit_len;
    int unsigned plen;
    bit          err;
    plen = ((int'(msg_len) + 9 + 63) / 64) * 64;
    err = len_overflow || plen > MAX_BYTES;
    for (int i = 0; i < 8; i++) h[i] = sha_pkg::IV[i];
    if (!err) begin
      padded = msg_bytes;
      padded.push_back(8'h80);
      while (padded.size() % 64 != 56) padded.push_back(8'h00);
      bit_len = 64'(msg_len) << 3;
      for (int i = 7; i >= 0; i--) padded.push_back(bit_len[8*i +: 8]);
      for (int b = 0; b < padded.size() / 64; b++) begin
        for (int i = 0; i < 64; i++) blk[i] = padded[64*b + i];
        sha_compress(h, blk);
      end
    end
    for (int i = 0; i < 8; i++)
      digest_q.push_back('{err ? 32'h0 : h[i], 3'(i), err, i == 7});
    msg_bytes.delete();
    msg_len = '0;
    len_overflow = 1'b0;
  endtask

  // Returns right after the accepting edge; valid drops only for a gap or a drain
  task automatic send_item(input logic [7:0] data, input logic has, input logic last);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= data;
    s_user  <= has;
    s_last  <= last;
    do @(posedge clk_i); while (!s_ready);
    if (has) begin
      if (msg_len == 16'hffff) len_overflow = 1'b1;
      else begin
        msg_bytes.push_back(data);
        msg_len++;
      end
    end
    if (last) predict_digest();
  endtask

  task automatic send_message(input int unsigned len);
    for (int i = 0; i < len; i++)
      send_item($urandom_range(0, 255), 1'b1, i == len - 1);
    if (len == 0) send_item($urandom_range(0, 255), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (digest_q.size() != 0) @(negedge clk_i);
  endtask

  // Result side: random stalls, compare each digest word with the oldest expected
  initial begin
    int unsigned stall;
    digest_beat_t got, want;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) stall = 0;
      @(negedge clk_i);
      if (stall != 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_valid);
      got = '{m_data[31:0], m_data[34:32], m_user, m_last};
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest word %h", got.word);
      end else begin
        want = digest_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: exp w=%h i=%0d tl=%b l=%b got w=%h i=%0d tl=%b l=%b",
                     want.word, want.idx, want.too_long, want.last,
                     got.word, got.idx, got.too_long, got.last);
        end
      end
    end
  end

  // Extremes of byte values, bare items, empty message
  task automatic test_directed();
    send_item(8'h00, 1'b0, 1'b1);            // empty message
    send_item(8'hff, 1'b0, 1'b0);            // bare item, ignored
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'ha5, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);            // "abc"
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);            // end with no byte
  endtask

  // Block boundaries: padding spilling over, a full block closed by data
  task automatic test_lengths();
    int unsigned lens[] = '{57, 64};
    foreach (lens[i]) send_message(lens[i]);
  endtask

  // Padded length beyond the maximum gives zero words with too_long
  task automatic test_too_long();
    send_message(248);
  endtask

  // Pause with the whole pipeline drained, then run with no idling
  task automatic test_drain_and_burst();
    wait_drained();
    no_idle = 1;
    send_message(5);
    send_message(3);
    no_idle = 0;
  endtask

  task automatic test_random();
    int unsigned sent = 0;
    int unsigned len;
    while (sent < 20) begin
      case ($urandom_range(0, 9))
        1: begin
          send_item($urandom_range(0, 255), 1'b0, 1'b0);
          len = 0;
        end
        default: len = $urandom_range(0, 6);
      endcase
      send_message(len);
      sent += (len == 0) ? 1 : len;
    end
  endtask

  initial begin
    msg_len = '0;
    len_overflow = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_lengths();
    test_too_long();
    test_drain_and_burst();
    test_random();
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/sha_pkg.sv
design/sha_core.sv
design/sha256_message_hash_top.sv
tb/tb_top.sv
